// ===== rtl/dcsd_pkg.sv =====
// Shared types and constants of the display command stream decoder.
// No dependencies; used by dcsd_decode and display_command_stream_decoder_top.
`default_nettype none

package dcsd_pkg;

  // Opcodes 15 and above are dropped in opcode position.
  localparam int OPCODE_COUNT  = 15;
  localparam int TESTER_POINTS = 480;

  localparam int STEP_W = 3;
  typedef logic [STEP_W-1:0] step_t;
  localparam step_t STEP_IDLE = 3'd0;
  localparam step_t STEP_MAX  = 3'd6;

  typedef enum logic [3:0] {
    OP_NOP     = 4'd0,
    OP_BUTTON  = 4'd1,
    OP_BEGIN   = 4'd2,
    OP_END     = 4'd3,
    OP_COLOR   = 4'd4,
    OP_FILL    = 4'd5,
    OP_TEXT    = 4'd6,
    OP_PALETTE = 4'd7,
    OP_RECT    = 4'd8,
    OP_VLINE   = 4'd9,
    OP_HLINE   = 4'd10,
    OP_FONT    = 4'd11,
    OP_POINT   = 4'd12,
    OP_LINE    = 4'd13,
    OP_TESTER  = 4'd14
  } op_t;

  typedef enum logic [3:0] {
    K_BEGIN   = 4'd0,
    K_END     = 4'd1,
    K_COLOR   = 4'd2,
    K_FILL    = 4'd3,
    K_TEXT    = 4'd4,
    K_PALETTE = 4'd5,
    K_RECT    = 4'd6,
    K_VLINE   = 4'd7,
    K_HLINE   = 4'd8,
    K_FONT    = 4'd9,
    K_POINT   = 4'd10,
    K_LINE    = 4'd11,
    K_TESTER  = 4'd12
  } kind_t;

  // One decoded drawing record.
  typedef struct packed {
    kind_t       kind;
    logic [15:0] x_pos;
    logic [7:0]  y_pos;
    logic [15:0] x_end;
    logic [7:0]  y_end;
    logic [31:0] value_word;
    logic [7:0]  aux_byte;
    logic [8:0]  element_index;
    logic [7:0]  element_byte;
    logic [8:0]  element_count;
    logic        last_element;
  } rec_t;

endpackage

`default_nettype wire

// ===== rtl/dcsd_decode.sv =====
// Command assembler: holds the per-command state and turns each accepted byte
// into at most one decoded record. Depends on dcsd_pkg.
`default_nettype none

module dcsd_decode (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          beat_valid,
  input  wire logic [7:0]    beat_byte,
  output dcsd_pkg::rec_t     res,
  output logic               res_valid
);

  dcsd_pkg::step_t step_r, step_nxt;
  dcsd_pkg::op_t   cmd_r, cmd_nxt;
  logic [15:0]     first_x_r, first_x_nxt;
  logic [7:0]      first_y_r, first_y_nxt;
  logic [15:0]     second_x_r, second_x_nxt;
  logic [31:0]     palette_r, palette_nxt;
  logic [7:0]      slot_r, slot_nxt;
  logic [7:0]      pcolor_r, pcolor_nxt;
  logic [7:0]      run_len_r, run_len_nxt;
  logic [8:0]      run_pos_r, run_pos_nxt;

  dcsd_pkg::op_t   cmd;
  logic            bad_op;
  logic            done;
  logic            hold;
  logic            last;
  logic [9:0]      pos_inc;

  assign bad_op  = (step_r == dcsd_pkg::STEP_IDLE) &&
                   (beat_byte >= 8'(dcsd_pkg::OPCODE_COUNT));
  assign cmd     = (step_r == dcsd_pkg::STEP_IDLE) ? dcsd_pkg::op_t'(beat_byte[3:0]) : cmd_r;
  assign pos_inc = {1'b0, run_pos_r} + 10'd1;

  always_comb begin
    step_nxt     = step_r;
    cmd_nxt      = cmd_r;
    first_x_nxt  = first_x_r;
    first_y_nxt  = first_y_r;
    second_x_nxt = second_x_r;
    palette_nxt  = palette_r;
    slot_nxt     = slot_r;
    pcolor_nxt   = pcolor_r;
    run_len_nxt  = run_len_r;
    run_pos_nxt  = run_pos_r;
    res          = '0;
    res_valid    = 1'b0;
    done         = 1'b0;
    hold         = 1'b0;
    last         = 1'b0;

    if (beat_valid && bad_op) begin
      cmd_nxt = dcsd_pkg::OP_NOP;
    end else if (beat_valid) begin
      cmd_nxt = cmd;
      unique case (cmd)
        dcsd_pkg::OP_NOP: begin
          done = 1'b1;
        end
        dcsd_pkg::OP_BUTTON: begin
          done = (step_r >= 3'd2);
        end
        dcsd_pkg::OP_BEGIN, dcsd_pkg::OP_COLOR, dcsd_pkg::OP_FONT: begin
          if (step_r != dcsd_pkg::STEP_IDLE) begin
            res_valid      = 1'b1;
            res.kind       = (cmd == dcsd_pkg::OP_BEGIN) ? dcsd_pkg::K_BEGIN :
                             (cmd == dcsd_pkg::OP_COLOR) ? dcsd_pkg::K_COLOR :
                                                           dcsd_pkg::K_FONT;
            res.value_word = {24'd0, beat_byte};
            done           = 1'b1;
          end
        end
        dcsd_pkg::OP_END: begin
          res_valid = 1'b1;
          res.kind  = dcsd_pkg::K_END;
          done      = 1'b1;
        end
        dcsd_pkg::OP_FILL, dcsd_pkg::OP_RECT, dcsd_pkg::OP_LINE: begin
          unique case (step_r)
            3'd0: ;
            3'd1: first_x_nxt  = {8'd0, beat_byte};
            3'd2: first_x_nxt  = {beat_byte, first_x_r[7:0]};
            3'd3: first_y_nxt  = beat_byte;
            3'd4: second_x_nxt = {8'd0, beat_byte};
            3'd5: second_x_nxt = {beat_byte, second_x_r[7:0]};
            default: begin
              res_valid = 1'b1;
              res.kind  = (cmd == dcsd_pkg::OP_FILL) ? dcsd_pkg::K_FILL :
                          (cmd == dcsd_pkg::OP_RECT) ? dcsd_pkg::K_RECT :
                                                       dcsd_pkg::K_LINE;
              res.x_pos = first_x_r;
              res.y_pos = first_y_r;
              res.x_end = second_x_r;
              res.y_end = beat_byte;
              done      = 1'b1;
            end
          endcase
        end
        dcsd_pkg::OP_TEXT: begin
          unique case (step_r)
            3'd0: ;
            3'd1: first_x_nxt = {8'd0, beat_byte};
            3'd2: first_x_nxt = {beat_byte, first_x_r[7:0]};
            3'd3: first_y_nxt = beat_byte;
            3'd4: begin
              run_len_nxt = beat_byte;
              run_pos_nxt = '0;
              // An empty text completes at once with a single closing record.
              if (beat_byte == 8'd0) begin
                res_valid        = 1'b1;
                res.kind         = dcsd_pkg::K_TEXT;
                res.x_pos        = first_x_r;
                res.y_pos        = first_y_r;
                res.last_element = 1'b1;
                done             = 1'b1;
              end
            end
            default: begin
              hold              = 1'b1;
              last              = (pos_inc >= {2'd0, run_len_r});
              res_valid         = 1'b1;
              res.kind          = dcsd_pkg::K_TEXT;
              res.x_pos         = first_x_r;
              res.y_pos         = first_y_r;
              res.element_index = run_pos_r;
              res.element_byte  = beat_byte;
              res.element_count = {1'b0, run_len_r};
              res.last_element  = last;
              run_pos_nxt       = pos_inc[8:0];
              done              = last;
            end
          endcase
        end
        dcsd_pkg::OP_PALETTE: begin
          unique case (step_r)
            3'd0: ;
            3'd1: slot_nxt    = beat_byte;
            3'd2: palette_nxt = {24'd0, beat_byte};
            3'd3: palette_nxt = {16'd0, beat_byte, palette_r[7:0]};
            3'd4: palette_nxt = {8'd0, beat_byte, palette_r[15:0]};
            default: begin
              palette_nxt    = {beat_byte, palette_r[23:0]};
              res_valid      = 1'b1;
              res.kind       = dcsd_pkg::K_PALETTE;
              res.value_word = {beat_byte, palette_r[23:0]};
              res.aux_byte   = slot_r;
              done           = 1'b1;
            end
          endcase
        end
        dcsd_pkg::OP_VLINE: begin
          unique case (step_r)
            3'd0: ;
            3'd1: first_x_nxt = {8'd0, beat_byte};
            3'd2: first_x_nxt = {beat_byte, first_x_r[7:0]};
            3'd3: first_y_nxt = beat_byte;
            default: begin
              res_valid = 1'b1;
              res.kind  = dcsd_pkg::K_VLINE;
              res.x_pos = first_x_r;
              res.y_pos = first_y_r;
              res.y_end = beat_byte;
              done      = 1'b1;
            end
          endcase
        end
        dcsd_pkg::OP_HLINE: begin
          unique case (step_r)
            3'd0: ;
            3'd1: first_y_nxt  = beat_byte;
            3'd2: first_x_nxt  = {8'd0, beat_byte};
            3'd3: first_x_nxt  = {beat_byte, first_x_r[7:0]};
            3'd4: second_x_nxt = {8'd0, beat_byte};
            default: begin
              second_x_nxt = {beat_byte, second_x_r[7:0]};
              res_valid    = 1'b1;
              res.kind     = dcsd_pkg::K_HLINE;
              res.x_pos    = first_x_r;
              res.y_pos    = first_y_r;
              res.x_end    = {beat_byte, second_x_r[7:0]};
              done         = 1'b1;
            end
          endcase
        end
        dcsd_pkg::OP_POINT: begin
          unique case (step_r)
            3'd0: ;
            3'd1: first_x_nxt = {8'd0, beat_byte};
            3'd2: first_x_nxt = {beat_byte, first_x_r[7:0]};
            default: begin
              res_valid = 1'b1;
              res.kind  = dcsd_pkg::K_POINT;
              res.x_pos = first_x_r;
              res.y_pos = beat_byte;
              done      = 1'b1;
            end
          endcase
        end
        dcsd_pkg::OP_TESTER: begin
          unique case (step_r)
            3'd0: run_pos_nxt = '0;
            3'd1: slot_nxt    = beat_byte;
            3'd2: pcolor_nxt  = beat_byte;
            default: begin
              hold              = 1'b1;
              last              = (pos_inc >= 10'(dcsd_pkg::TESTER_POINTS));
              res_valid         = 1'b1;
              res.kind          = dcsd_pkg::K_TESTER;
              res.value_word    = {24'd0, slot_r};
              res.aux_byte      = pcolor_r;
              res.element_index = run_pos_r;
              res.element_byte  = beat_byte;
              res.element_count = 9'(dcsd_pkg::TESTER_POINTS);
              res.last_element  = last;
              run_pos_nxt       = pos_inc[8:0];
              done              = last;
            end
          endcase
        end
        default: begin
          done = 1'b1;
        end
      endcase

      if (done) begin
        step_nxt = dcsd_pkg::STEP_IDLE;
        cmd_nxt  = dcsd_pkg::OP_NOP;
      end else if (!hold) begin
        step_nxt = step_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= dcsd_pkg::STEP_IDLE;
      cmd_r  <= dcsd_pkg::OP_NOP;
    end else begin
      step_r <= step_nxt;
      cmd_r  <= cmd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    first_x_r  <= first_x_nxt;
    first_y_r  <= first_y_nxt;
    second_x_r <= second_x_nxt;
    palette_r  <= palette_nxt;
    slot_r     <= slot_nxt;
    pcolor_r   <= pcolor_nxt;
    run_len_r  <= run_len_nxt;
    run_pos_r  <= run_pos_nxt;
  end

`ifndef NO_ASSERTIONS
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= dcsd_pkg::STEP_MAX)
    else $error("command step counter out of range");

  a_bad_opcode: assert property (@(posedge clk) disable iff (!rst_n)
    (beat_valid && bad_op) |-> (!res_valid ##1 (step_r == dcsd_pkg::STEP_IDLE)))
    else $error("unknown opcode was not dropped");

  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.last_element) |->
      (res.kind == dcsd_pkg::K_TEXT || res.kind == dcsd_pkg::K_TESTER))
    else $error("last mark on a record that is not part of a run");
`endif

endmodule

`default_nettype wire

// ===== rtl/display_command_stream_decoder_top.sv =====
// Top level of the display command stream decoder: byte input stream, decoded
// record output stream with a skid stage. Depends on dcsd_pkg and dcsd_decode.
//
//   Channel  Dir  Beat content                               Handshake
//   in_      in   one command byte (opcode or argument)      in_tvalid / in_tready
//   out_     out  one decoded drawing record                 out_tvalid / out_tready
//
// Every input beat is decoded in the cycle it is accepted; its record, if any, goes
// to the output register, or to the skid register while out_ stalls. A new byte
// can be taken in every cycle while the skid register is empty: the output register
// plus one skid register let input continue while a record waits; in_tready
// drops only when both hold a record. Reset (rst_n low, synchronous) returns
// the decoder to idle, waiting for an opcode, and empties both output registers.
`default_nettype none

module display_command_stream_decoder_top (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [7:0]   in_tdata,   // [7:0] data_byte
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // [15:0] x_pos, [23:16] y_pos, [39:24] x_end, [47:40] y_end,
  // [79:48] value_word, [87:80] aux_byte, [96:88] element_index,
  // [104:97] element_byte, [113:105] element_count, [119:114] zero
  output logic [119:0]      out_tdata,
  output logic [3:0]        out_tuser,  // [3:0] command_kind
  output logic              out_tlast   // last_element
);

  logic            in_accept;
  logic            out_take;
  logic            out_free;
  dcsd_pkg::rec_t  dec_res;
  logic            dec_valid;

  logic            out_valid_r, out_valid_nxt;
  dcsd_pkg::rec_t  out_rec_r, out_rec_nxt;
  logic            skid_valid_r, skid_valid_nxt;
  dcsd_pkg::rec_t  skid_rec_r, skid_rec_nxt;

  // No byte is taken while reset is held.
  assign in_tready = rst_n && !skid_valid_r;
  assign in_accept = in_tvalid && in_tready;
  assign out_take  = out_valid_r && out_tready;
  assign out_free  = !out_valid_r || out_tready;

  dcsd_decode u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .beat_valid (in_accept),
    .beat_byte  (in_tdata),
    .res        (dec_res),
    .res_valid  (dec_valid)
  );

  // A new record can only arrive while the skid register is empty, so the
  // skid register drains into the output register before anything else.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_rec_nxt    = out_rec_r;
    skid_valid_nxt = skid_valid_r;
    skid_rec_nxt   = skid_rec_r;
    if (skid_valid_r) begin
      if (out_free) begin
        out_valid_nxt  = 1'b1;
        out_rec_nxt    = skid_rec_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (in_accept && dec_valid) begin
      if (out_free) begin
        out_valid_nxt = 1'b1;
        out_rec_nxt   = dec_res;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_rec_nxt   = dec_res;
      end
    end else if (out_take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_rec_r  <= out_rec_nxt;
    skid_rec_r <= skid_rec_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_rec_r.kind;
  assign out_tlast  = out_rec_r.last_element;
  assign out_tdata  = {6'd0,
                       out_rec_r.element_count,
                       out_rec_r.element_byte,
                       out_rec_r.element_index,
                       out_rec_r.aux_byte,
                       out_rec_r.value_word,
                       out_rec_r.y_end,
                       out_rec_r.x_end,
                       out_rec_r.y_pos,
                       out_rec_r.x_pos};

`ifndef NO_ASSERTIONS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register holds a record while the output is empty");

  a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(out_valid_r && !out_tready && in_accept && dec_valid))
    else $error("skid register filled without an output stall");

  a_stall_goes_to_skid: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && dec_valid && out_valid_r && !out_tready) |=> skid_valid_r)
    else $error("record produced during a stall was lost");
`endif

endmodule

`default_nettype wire

// ===== sim/display_command_stream_decoder_top_test.sv =====
// Self-checking testbench for display_command_stream_decoder_top: drives command
// bytes with random gaps and stalls, predicts each decoded record and checks it.
// Depends on dcsd_pkg and the RTL of the decoder; needs nothing else.
`default_nettype none

module display_command_stream_decoder_top_test;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int RANDOM_ITEMS = 1900;
  localparam int LONG_HOLD    = 300;
  localparam int LONG_HOLD_AT = 100;
  localparam int END_WAIT     = 16;
  localparam int PRINT_CAP    = 40;

  // One byte of stimulus; typed rows carry a hand-written expected record,
  // and settle rows make the sender wait until every record has come back.
  typedef struct {
    logic [7:0]     data;
    bit             typed;
    bit             settle;
    dcsd_pkg::rec_t rec;
  } stim_row_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [7:0]   in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [119:0] out_tdata;
  logic [3:0]   out_tuser;
  logic         out_tlast;

  stim_row_t      stim_rows[$];
  dcsd_pkg::rec_t pending_records[$];
  bit             next_settle;
  bit             sender_done;
  bit             snd_calm;
  bit             rcv_calm;
  bit             long_hold_done;
  int             fail_count;
  int             cycle_count;
  int             bytes_sent;
  int             records_checked;
  int             items_queued;
  int             text_runs;
  int             tester_runs;

  // Decoder state as the predictor sees it.
  logic [8:0]    step_cnt;
  dcsd_pkg::op_t cur_op;
  logic [15:0]   fx;
  logic [7:0]    fy;
  logic [15:0]   sx;
  logic [31:0]   pal_word;
  logic [7:0]    slot_mode;
  logic [7:0]    pt_color;
  logic [7:0]    run_len;
  logic [8:0]    run_pos;

  display_command_stream_decoder_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d records outstanding.", cycle_count,
               pending_records.size());
      $display("display_command_stream_decoder_top_test: FAIL");
      $finish;
    end
  end

  function automatic dcsd_pkg::rec_t make_rec(dcsd_pkg::kind_t k, logic [15:0] x,
                                              logic [7:0] y, logic [15:0] xe,
                                              logic [7:0] ye, logic [31:0] v,
                                              logic [7:0] a, logic [8:0] idx,
                                              logic [7:0] eb, logic [8:0] cnt,
                                              logic lst);
    dcsd_pkg::rec_t r;
    r.kind = k;
    r.x_pos = x;
    r.y_pos = y;
    r.x_end = xe;
    r.y_end = ye;
    r.value_word = v;
    r.aux_byte = a;
    r.element_index = idx;
    r.element_byte = eb;
    r.element_count = cnt;
    r.last_element = lst;
    return r;
  endfunction

  // Advances the predicted decoder by one byte; returns 1 when the byte
  // completes a record, which is then left in r.
  function automatic bit decode_command_byte(input logic [7:0] d,
                                             output dcsd_pkg::rec_t r);
    bit         fin;
    bit         hold;
    bit         got;
    bit         lst;
    logic [8:0] s;
    r = '0;
    fin = 1'b0;
    hold = 1'b0;
    got = 1'b0;
    s = step_cnt;
    if (s == 0) begin
      if (d >= dcsd_pkg::OPCODE_COUNT) begin
        cur_op = dcsd_pkg::OP_NOP;
        return 1'b0;
      end
      cur_op = dcsd_pkg::op_t'(d[3:0]);
    end
    case (cur_op)
      dcsd_pkg::OP_NOP: fin = 1'b1;
      dcsd_pkg::OP_BUTTON: fin = (s >= 2);
      dcsd_pkg::OP_BEGIN, dcsd_pkg::OP_COLOR, dcsd_pkg::OP_FONT: begin
        if (s >= 1) begin
          r = make_rec(cur_op == dcsd_pkg::OP_BEGIN ? dcsd_pkg::K_BEGIN :
                       (cur_op == dcsd_pkg::OP_COLOR ? dcsd_pkg::K_COLOR :
                                                      dcsd_pkg::K_FONT),
                       0, 0, 0, 0, {24'd0, d}, 0, 0, 0, 0, 1'b0);
          got = 1'b1;
          fin = 1'b1;
        end
      end
      dcsd_pkg::OP_END: begin
        r = make_rec(dcsd_pkg::K_END, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0);
        got = 1'b1;
        fin = 1'b1;
      end
      dcsd_pkg::OP_FILL, dcsd_pkg::OP_RECT, dcsd_pkg::OP_LINE: begin
        case (s)
          0: ;
          1: fx = {8'd0, d};
          2: fx = {d, fx[7:0]};
          3: fy = d;
          4: sx = {8'd0, d};
          5: sx = {d, sx[7:0]};
          default: begin
            r = make_rec(cur_op == dcsd_pkg::OP_FILL ? dcsd_pkg::K_FILL :
                         (cur_op == dcsd_pkg::OP_RECT ? dcsd_pkg::K_RECT :
                                                        dcsd_pkg::K_LINE),
                         fx, fy, sx, d, 0, 0, 0, 0, 0, 1'b0);
            got = 1'b1;
            fin = 1'b1;
          end
        endcase
      end
      dcsd_pkg::OP_TEXT: begin
        case (s)
          0: ;
          1: fx = {8'd0, d};
          2: fx = {d, fx[7:0]};
          3: fy = d;
          4: begin
            run_len = d;
            run_pos = '0;
            // A zero count finishes the text at once with an empty record.
            if (d == 0) begin
              r = make_rec(dcsd_pkg::K_TEXT, fx, fy, 0, 0, 0, 0, 0, 0, 0, 1'b1);
              got = 1'b1;
              fin = 1'b1;
            end
          end
          default: begin
            hold = 1'b1;
            lst = (int'(run_pos) + 1 >= int'(run_len));
            r = make_rec(dcsd_pkg::K_TEXT, fx, fy, 0, 0, 0, 0, run_pos, d,
                         {1'b0, run_len}, lst);
            got = 1'b1;
            run_pos = run_pos + 9'd1;
            fin = lst;
          end
        endcase
      end
      dcsd_pkg::OP_PALETTE: begin
        case (s)
          0: ;
          1: slot_mode = d;
          2: pal_word = {24'd0, d};
          3: pal_word = {16'd0, d, pal_word[7:0]};
          4: pal_word = {8'd0, d, pal_word[15:0]};
          default: begin
            pal_word = {d, pal_word[23:0]};
            r = make_rec(dcsd_pkg::K_PALETTE, 0, 0, 0, 0, pal_word, slot_mode, 0, 0, 0,
                         1'b0);
            got = 1'b1;
            fin = 1'b1;
          end
        endcase
      end
      dcsd_pkg::OP_VLINE: begin
        case (s)
          0: ;
          1: fx = {8'd0, d};
          2: fx = {d, fx[7:0]};
          3: fy = d;
          default: begin
            r = make_rec(dcsd_pkg::K_VLINE, fx, fy, 0, d, 0, 0, 0, 0, 0, 1'b0);
            got = 1'b1;
            fin = 1'b1;
          end
        endcase
      end
      dcsd_pkg::OP_HLINE: begin
        case (s)
          0: ;
          1: fy = d;
          2: fx = {8'd0, d};
          3: fx = {d, fx[7:0]};
          4: sx = {8'd0, d};
          default: begin
            sx = {d, sx[7:0]};
            r = make_rec(dcsd_pkg::K_HLINE, fx, fy, sx, 0, 0, 0, 0, 0, 0, 1'b0);
            got = 1'b1;
            fin = 1'b1;
          end
        endcase
      end
      dcsd_pkg::OP_POINT: begin
        case (s)
          0: ;
          1: fx = {8'd0, d};
          2: fx = {d, fx[7:0]};
          default: begin
            r = make_rec(dcsd_pkg::K_POINT, fx, d, 0, 0, 0, 0, 0, 0, 0, 1'b0);
            got = 1'b1;
            fin = 1'b1;
          end
        endcase
      end
      default: begin
        // Tester: mode, color, then a fixed run of samples.
        case (s)
          0: run_pos = '0;
          1: slot_mode = d;
          2: pt_color = d;
          default: begin
            hold = 1'b1;
            lst = (int'(run_pos) + 1 >= dcsd_pkg::TESTER_POINTS);
            r = make_rec(dcsd_pkg::K_TESTER, 0, 0, 0, 0, {24'd0, slot_mode}, pt_color,
                         run_pos, d, 9'(dcsd_pkg::TESTER_POINTS), lst);
            got = 1'b1;
            run_pos = run_pos + 9'd1;
            fin = lst;
          end
        endcase
      end
    endcase
    if (fin) begin
      step_cnt = '0;
      cur_op = dcsd_pkg::OP_NOP;
    end else if (!hold) begin
      step_cnt = step_cnt + 9'd1;
    end
    return got;
  endfunction

  function automatic logic [7:0] rand_byte();
    int pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) return 8'h00;
    if (pick == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  // Gap before the next beat; a side sometimes switches into a run with no gaps.
  function automatic int draw_gap(inout bit calm);
    if ($urandom_range(0, 63) == 0) calm = !calm;
    if (calm || $urandom_range(0, 1) == 0) return 0;
    return $urandom_range(0, 16);
  endfunction

  task automatic add_row(input logic [7:0] b, input bit counted = 1'b1);
    stim_row_t row;
    row.data = b;
    row.typed = 1'b0;
    row.settle = next_settle;
    row.rec = '0;
    next_settle = 1'b0;
    stim_rows.push_back(row);
    if (counted) items_queued++;
  endtask

  task automatic add_typed(input logic [7:0] b, input dcsd_pkg::rec_t want);
    stim_row_t row;
    row.data = b;
    row.typed = 1'b1;
    row.settle = 1'b0;
    row.rec = want;
    stim_rows.push_back(row);
    items_queued++;
  endtask

  // Prints one line per mismatch, up to a cap, and counts every one.
  task automatic report_mismatch(input string msg);
    if (fail_count < PRINT_CAP) $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    fail_count++;
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("record %0d %s got 0x%0h expected 0x%0h",
                                records_checked, name, got, want));
  endtask

  // Sender: walks the stimulus rows, predicting each byte when it is accepted.
  initial begin
    stim_row_t      row;
    dcsd_pkg::rec_t r;
    bit             got;
    int             gap;
    wait (rst_n === 1'b1);
    while (stim_rows.size() != 0) begin
      row = stim_rows.pop_front();
      if (row.settle) begin
        in_tvalid = 1'b0;
        while (pending_records.size() != 0) @(negedge clk);
      end
      gap = draw_gap(snd_calm);
      if (gap != 0) begin
        in_tvalid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      in_tdata = row.data;
      in_tvalid = 1'b1;
      do @(posedge clk); while (in_tready !== 1'b1);
      got = decode_command_byte(row.data, r);
      if (row.typed) pending_records.push_back(row.rec);
      else if (got) pending_records.push_back(r);
      bytes_sent++;
      @(negedge clk);
    end
    in_tvalid = 1'b0;
    sender_done = 1'b1;
  end

  // Receiver: random ready gaps, one long hold-off inside the first tester run
  // (or after a fixed number of records if no tester run has come by then) so
  // that the output stage and its skid register both fill and stall the input.
  initial begin
    dcsd_pkg::rec_t got;
    dcsd_pkg::rec_t want;
    int             gap;
    wait (rst_n === 1'b1);
    forever begin
      gap = draw_gap(rcv_calm);
      if (gap != 0) begin
        out_tready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
      got.kind = dcsd_pkg::kind_t'(out_tuser);
      got.x_pos = out_tdata[15:0];
      got.y_pos = out_tdata[23:16];
      got.x_end = out_tdata[39:24];
      got.y_end = out_tdata[47:40];
      got.value_word = out_tdata[79:48];
      got.aux_byte = out_tdata[87:80];
      got.element_index = out_tdata[96:88];
      got.element_byte = out_tdata[104:97];
      got.element_count = out_tdata[113:105];
      got.last_element = out_tlast;
      records_checked++;
      if (pending_records.size() == 0) begin
        report_mismatch($sformatf("record of kind %0d with none expected", out_tuser));
      end else begin
        want = pending_records.pop_front();
        compare_field("command_kind", 32'(got.kind), 32'(want.kind));
        compare_field("x_pos", 32'(got.x_pos), 32'(want.x_pos));
        compare_field("y_pos", 32'(got.y_pos), 32'(want.y_pos));
        compare_field("x_end", 32'(got.x_end), 32'(want.x_end));
        compare_field("y_end", 32'(got.y_end), 32'(want.y_end));
        compare_field("value_word", got.value_word, want.value_word);
        compare_field("aux_byte", 32'(got.aux_byte), 32'(want.aux_byte));
        compare_field("element_index", 32'(got.element_index), 32'(want.element_index));
        compare_field("element_byte", 32'(got.element_byte), 32'(want.element_byte));
        compare_field("element_count", 32'(got.element_count), 32'(want.element_count));
        compare_field("last_element", 32'(got.last_element), 32'(want.last_element));
      end
      @(negedge clk);
      if (!long_hold_done &&
          ((got.kind == dcsd_pkg::K_TESTER && got.element_index == 9'd10) ||
           records_checked == LONG_HOLD_AT)) begin
        long_hold_done = 1'b1;
        out_tready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end
    end
  end

  initial begin
    int            cmd_no;
    int            pick;
    int            n;
    int            len;
    dcsd_pkg::op_t op;
    in_tvalid = 1'b0;
    in_tdata = 8'd0;
    out_tready = 1'b0;
    rst_n = 1'b0;
    next_settle = 1'b0;
    sender_done = 1'b0;
    snd_calm = 1'b0;
    rcv_calm = 1'b0;
    long_hold_done = 1'b0;
    fail_count = 0;
    cycle_count = 0;
    bytes_sent = 0;
    records_checked = 0;
    items_queued = 0;
    text_runs = 0;
    tester_runs = 0;
    step_cnt = '0;
    cur_op = dcsd_pkg::OP_NOP;
    fx = '0;
    fy = '0;
    sx = '0;
    pal_word = '0;
    slot_mode = '0;
    pt_color = '0;
    run_len = '0;
    run_pos = '0;

    // Directed part: dropped opcodes, the one-byte commands, field extremes,
    // an empty text and a one-character text.
    add_row(8'hFF, 1'b0);
    add_row(8'(dcsd_pkg::OPCODE_COUNT), 1'b0);
    add_row(dcsd_pkg::OP_NOP);
    add_typed(dcsd_pkg::OP_END,
              make_rec(dcsd_pkg::K_END, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
    add_row(dcsd_pkg::OP_BEGIN);
    add_typed(8'hFF, make_rec(dcsd_pkg::K_BEGIN, 0, 0, 0, 0, 32'hFF, 0, 0, 0, 0, 1'b0));
    add_row(dcsd_pkg::OP_BUTTON);
    add_row(8'hFF);
    add_row(8'h00);
    add_row(8'hA5);
    add_row(dcsd_pkg::OP_TEXT);
    repeat (3) add_row(8'hFF);
    add_typed(8'h00, make_rec(dcsd_pkg::K_TEXT, 16'hFFFF, 8'hFF, 0, 0, 0, 0, 0, 0, 0,
                              1'b1));
    add_row(dcsd_pkg::OP_FILL);
    repeat (5) add_row(8'hFF);
    add_typed(8'hFF, make_rec(dcsd_pkg::K_FILL, 16'hFFFF, 8'hFF, 16'hFFFF, 8'hFF, 0, 0,
                              0, 0, 0, 1'b0));
    add_row(dcsd_pkg::OP_TEXT);
    repeat (3) add_row(8'h00);
    add_row(8'h01);
    add_typed(8'h41, make_rec(dcsd_pkg::K_TEXT, 0, 0, 0, 0, 0, 0, 0, 8'h41, 9'd1, 1'b1));

    // Random part: mostly well-formed commands with random arguments, some
    // dropped opcodes and stray bytes that knock the framing off.
    items_queued = 0;
    cmd_no = 0;
    next_settle = 1'b1;
    while (items_queued < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        add_row(8'($urandom_range(dcsd_pkg::OPCODE_COUNT, 255)), 1'b0);
      end else if (pick < 9) begin
        add_row(rand_byte());
      end else begin
        if (cmd_no == 30 || $urandom_range(0, 299) == 0) op = dcsd_pkg::OP_TESTER;
        else op = dcsd_pkg::op_t'($urandom_range(0, 13));
        // Midway the sender stops until every record has come back.
        if (cmd_no == 150) next_settle = 1'b1;
        cmd_no++;
        add_row(op);
        case (op)
          dcsd_pkg::OP_NOP, dcsd_pkg::OP_END: n = 0;
          dcsd_pkg::OP_BEGIN, dcsd_pkg::OP_COLOR, dcsd_pkg::OP_FONT: n = 1;
          dcsd_pkg::OP_BUTTON: n = 2;
          dcsd_pkg::OP_POINT: n = 3;
          dcsd_pkg::OP_VLINE: n = 4;
          dcsd_pkg::OP_PALETTE, dcsd_pkg::OP_HLINE: n = 5;
          dcsd_pkg::OP_FILL, dcsd_pkg::OP_RECT, dcsd_pkg::OP_LINE: n = 6;
          dcsd_pkg::OP_TEXT: begin
            pick = $urandom_range(0, 99);
            if (pick < 70) len = $urandom_range(0, 8);
            else if (pick < 95) len = $urandom_range(9, 40);
            else if (pick < 99) len = $urandom_range(41, 254);
            else len = 255;
            repeat (3) add_row(rand_byte());
            add_row(8'(len));
            n = len;
            text_runs++;
          end
          default: begin
            n = 2 + dcsd_pkg::TESTER_POINTS;
            tester_runs++;
          end
        endcase
        repeat (n) add_row(rand_byte());
      end
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    wait (sender_done);
    while (pending_records.size() != 0) @(posedge clk);
    repeat (END_WAIT) @(posedge clk);

    $display("Sent %0d command bytes over %0d random commands, %0d text and %0d tester runs.",
             bytes_sent, cmd_no, text_runs, tester_runs);
    $display("Checked %0d records under random gaps, a long output hold-off and a drain pause.",
             records_checked);
    if (fail_count == 0) begin
      $display("display_command_stream_decoder_top_test: PASS");
    end else begin
      $display("%0d mismatches.", fail_count);
      $display("display_command_stream_decoder_top_test: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
